[sv/assert_macros.svh]
// Assertion macros shared by the router RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_AT(name, clk, rstn, prop) \
	name: assert property (@(posedge clk) disable iff (!rstn) prop) \
		else $error("assertion failed");
`define ASSERT_NEVER(name, clk, rstn, expr) \
	name: assert property (@(posedge clk) disable iff (!rstn) !(expr)) \
		else $error("forbidden condition seen");
`else
`define ASSERT_AT(name, clk, rstn, prop)
`define ASSERT_NEVER(name, clk, rstn, expr)
`endif
`endif

[sv/selr_pkg.sv]
// Shared constants, types and helpers of the spike event label router.
package selr_pkg;

	localparam int CHANNELS  = 8;
	localparam int LABELS    = 512;
	localparam int TIME_BITS = 15;

	localparam int CH_W    = 3;
	localparam int LABEL_W = 9;
	localparam int TS_W    = 15;
	localparam int MASK_W  = 64;

	localparam int TABLE_DEPTH = CHANNELS * LABELS;
	localparam int ADDR_W      = $clog2(TABLE_DEPTH);

	localparam logic [TS_W-1:0] TIME_MASK = TS_W'((1 << TIME_BITS) - 1);

	localparam logic [1:0] OP_CHIP_EVT = 2'd0;
	localparam logic [1:0] OP_HOST_EVT = 2'd1;
	localparam logic [1:0] OP_ROUTE_WR = 2'd2;

	localparam logic [1:0] ST_TO_HOST = 2'd0;
	localparam logic [1:0] ST_TO_CHIP = 2'd1;
	localparam logic [1:0] ST_REJECT  = 2'd2;
	localparam logic [1:0] ST_WRITE   = 2'd3;

	typedef struct packed {
		logic              en;
		logic [ADDR_W-1:0] addr;
		logic [TS_W-1:0]   data;
	} selr_wr_t;

	function automatic logic [ADDR_W-1:0] table_addr(input logic [CH_W-1:0] ch,
			input logic [LABEL_W-1:0] lab);
		return ADDR_W'(32'(ch) * LABELS + 32'(lab));
	endfunction

	function automatic logic in_table(input logic [CH_W-1:0] ch,
			input logic [LABEL_W-1:0] lab);
		return (32'(ch) < CHANNELS) && (32'(lab) < LABELS);
	endfunction

	// bit channel*8 + bus group of the direction mask
	function automatic logic [5:0] dir_index(input logic [CH_W-1:0] ch,
			input logic [LABEL_W-1:0] lab);
		return {ch, lab[LABEL_W-1:LABEL_W-3]};
	endfunction

endpackage

[sv/selr_ram.sv]
// Single-port-write, single-port-read synchronous RAM with registered read data.
module selr_ram #(
	parameter int DEPTH = 4096,
	parameter int WIDTH = 15
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

[sv/selr_route.sv]
// Route pipeline: table read, delay add, direction check, result register.
`include "assert_macros.svh"

module selr_route (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  accept,
	input  logic [1:0]                            opcode,
	input  logic [selr_pkg::CH_W-1:0]             channel,
	input  logic [selr_pkg::LABEL_W-1:0]          label,
	input  logic [selr_pkg::TS_W-1:0]             timestamp,
	input  logic [selr_pkg::TS_W-1:0]             delay_value,
	input  logic [selr_pkg::MASK_W-1:0]           direction_mask,
	output logic                                  rd_en,
	output logic [selr_pkg::ADDR_W-1:0]           rd_addr,
	input  logic [selr_pkg::TS_W-1:0]             rd_data,
	output selr_pkg::selr_wr_t                    wr_req,
	output logic                                  done,
	output logic [1:0]                            status,
	output logic [selr_pkg::CH_W-1:0]             out_channel,
	output logic [selr_pkg::LABEL_W-1:0]          out_label,
	output logic [selr_pkg::TS_W-1:0]             out_time
);

	logic                            vld_s1;
	logic [1:0]                      op_s1;
	logic [selr_pkg::CH_W-1:0]       ch_s1;
	logic [selr_pkg::LABEL_W-1:0]    lab_s1;
	logic [selr_pkg::TS_W-1:0]       ts_s1;
	logic [selr_pkg::TS_W-1:0]       dv_s1;
	logic [selr_pkg::ADDR_W-1:0]     addr_s1;
	logic                            inrange_s1;
	logic                            fwd_s1;
	logic [selr_pkg::TS_W-1:0]       fwd_data_s1;

	logic                            done_q;
	logic [1:0]                      status_q;
	logic [selr_pkg::CH_W-1:0]       ch_q;
	logic [selr_pkg::LABEL_W-1:0]    lab_q;
	logic [selr_pkg::TS_W-1:0]       time_q;

	logic [selr_pkg::TS_W-1:0]       delay;
	logic                            dir_bit;
	logic [1:0]                      status_d;
	logic [selr_pkg::TS_W-1:0]       time_d;

	assign rd_en   = accept;
	assign rd_addr = selr_pkg::table_addr(channel, label);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else begin
			vld_s1 <= accept;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			op_s1       <= opcode;
			ch_s1       <= channel;
			lab_s1      <= label;
			ts_s1       <= timestamp;
			dv_s1       <= delay_value;
			addr_s1     <= rd_addr;
			inrange_s1  <= selr_pkg::in_table(channel, label);
			// the RAM returns stale data when the beat ahead writes the same entry
			fwd_s1      <= wr_req.en && (wr_req.addr == rd_addr);
			fwd_data_s1 <= wr_req.data;
		end
	end

	assign delay   = fwd_s1 ? fwd_data_s1 : rd_data;
	assign dir_bit = direction_mask[selr_pkg::dir_index(ch_s1, lab_s1)];

	assign wr_req.en   = vld_s1 && (op_s1 == selr_pkg::OP_ROUTE_WR) && inrange_s1;
	assign wr_req.addr = addr_s1;
	assign wr_req.data = dv_s1;

	always_comb begin
		status_d = selr_pkg::ST_REJECT;
		time_d   = '0;
		case (op_s1)
			selr_pkg::OP_CHIP_EVT: begin
				if (inrange_s1 && !dir_bit) begin
					status_d = selr_pkg::ST_TO_HOST;
					time_d   = (ts_s1 + delay) & selr_pkg::TIME_MASK;
				end
			end
			selr_pkg::OP_HOST_EVT: begin
				if (inrange_s1 && dir_bit) begin
					status_d = selr_pkg::ST_TO_CHIP;
					time_d   = ts_s1 & selr_pkg::TIME_MASK;
				end
			end
			selr_pkg::OP_ROUTE_WR: begin
				status_d = selr_pkg::ST_WRITE;
			end
			default: begin
				status_d = selr_pkg::ST_REJECT;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (vld_s1) begin
			status_q <= status_d;
			ch_q     <= ch_s1;
			lab_q    <= lab_s1;
			time_q   <= time_d;
		end
	end

	assign done        = done_q;
	assign status      = status_q;
	assign out_channel = ch_q;
	assign out_label   = lab_q;
	assign out_time    = time_q;

	`ASSERT_AT(a_done_follows_s1, clk, arst_n, vld_s1 |=> done_q)
	`ASSERT_AT(a_no_spurious_done, clk, arst_n, !vld_s1 |=> !done_q)
	`ASSERT_AT(a_fwd_needs_write, clk, arst_n, $rose(vld_s1) && fwd_s1 |-> $past(wr_req.en))
	`ASSERT_NEVER(a_reject_time_zero, clk, arst_n,
		done_q && (status_q == selr_pkg::ST_REJECT) && (time_q != '0))

endmodule

[sv/spike_event_label_router.sv]
// Spike event label router top level: direction register, table clear and RAM.
//
// One item is taken per clock cycle whenever busy is low. Its result shows on
// status/out_* with done high for one cycle, once it has passed through the s1
// registers and the result register. The receiver cannot stall,
// so every beat must be taken when done is high.
// After reset the block sweeps the 4096-entry delay RAM to zero, one entry per
// cycle, and holds busy high until the sweep ends; direction_mask writes are
// taken during that sweep. A table write followed at once by an event for the
// same entry sees the new delay through a bypass around the RAM read port.
`include "assert_macros.svh"

module spike_event_label_router (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  start,
	output logic                                  busy,
	input  logic [1:0]                            opcode,
	input  logic [selr_pkg::CH_W-1:0]             channel,
	input  logic [selr_pkg::LABEL_W-1:0]          label,
	input  logic [selr_pkg::TS_W-1:0]             timestamp,
	input  logic [selr_pkg::TS_W-1:0]             delay_value,
	input  logic                                  cfg_we,
	input  logic [selr_pkg::MASK_W-1:0]           cfg_wdata,
	output logic                                  done,
	output logic [1:0]                            status,
	output logic [selr_pkg::CH_W-1:0]             out_channel,
	output logic [selr_pkg::LABEL_W-1:0]          out_label,
	output logic [selr_pkg::TS_W-1:0]             out_time
);

	logic [selr_pkg::MASK_W-1:0]  direction_mask_q;
	logic                         clearing_q;
	logic [selr_pkg::ADDR_W-1:0]  clr_addr_q;

	logic                         accept;
	logic                         rd_en;
	logic [selr_pkg::ADDR_W-1:0]  rd_addr;
	logic [selr_pkg::TS_W-1:0]    rd_data;
	selr_pkg::selr_wr_t           wr_req;

	logic                         ram_we;
	logic [selr_pkg::ADDR_W-1:0]  ram_waddr;
	logic [selr_pkg::TS_W-1:0]    ram_wdata;

	assign busy   = clearing_q;
	assign accept = start && !busy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			direction_mask_q <= '0;
		end else if (cfg_we) begin
			direction_mask_q <= cfg_wdata;
		end
	end

	// zero the delay RAM after reset, one entry per cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clearing_q <= 1'b1;
			clr_addr_q <= '0;
		end else if (clearing_q) begin
			clr_addr_q <= clr_addr_q + selr_pkg::ADDR_W'(1);
			if (clr_addr_q == selr_pkg::ADDR_W'(selr_pkg::TABLE_DEPTH - 1)) begin
				clearing_q <= 1'b0;
			end
		end
	end

	assign ram_we    = clearing_q || wr_req.en;
	assign ram_waddr = clearing_q ? clr_addr_q : wr_req.addr;
	assign ram_wdata = clearing_q ? '0 : wr_req.data;

	selr_ram #(
		.DEPTH (selr_pkg::TABLE_DEPTH),
		.WIDTH (selr_pkg::TS_W)
	) u_delay_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (rd_en),
		.raddr (rd_addr),
		.rdata (rd_data)
	);

	selr_route u_route (
		.clk            (clk),
		.arst_n         (arst_n),
		.accept         (accept),
		.opcode         (opcode),
		.channel        (channel),
		.label          (label),
		.timestamp      (timestamp),
		.delay_value    (delay_value),
		.direction_mask (direction_mask_q),
		.rd_en          (rd_en),
		.rd_addr        (rd_addr),
		.rd_data        (rd_data),
		.wr_req         (wr_req),
		.done           (done),
		.status         (status),
		.out_channel    (out_channel),
		.out_label      (out_label),
		.out_time       (out_time)
	);

	`ASSERT_NEVER(a_no_result_while_clearing, clk, arst_n, clearing_q && done)
	`ASSERT_AT(a_clear_ends_at_last, clk, arst_n,
		$fell(clearing_q) |-> ($past(clr_addr_q) ==
			selr_pkg::ADDR_W'(selr_pkg::TABLE_DEPTH - 1)))
	`ASSERT_NEVER(a_no_item_write_while_clearing, clk, arst_n, clearing_q && wr_req.en)

endmodule

[tb/tb_spike_event_label_router.sv]
// Testbench of the spike event label router: directed and random beats checked against a predictor.
module tb_spike_event_label_router;
	import selr_pkg::*;

	localparam logic [1:0] OP_UNUSED = 2'd3;
	localparam int CYCLE_LIMIT = 200000;
	localparam logic [MASK_W-1:0] MASK_ONES = '1;
	localparam logic [MASK_W-1:0] MASK_ODD_GROUPS = 64'haaaa_aaaa_aaaa_aaaa;
	localparam int HOT_ENTRIES = 6;

	typedef struct packed {
		logic [1:0]         op;
		logic [CH_W-1:0]    ch;
		logic [LABEL_W-1:0] lab;
		logic [TS_W-1:0]    ts;
		logic [TS_W-1:0]    dv;
	} route_item_t;

	typedef struct packed {
		logic [1:0]         st;
		logic [CH_W-1:0]    ch;
		logic [LABEL_W-1:0] lab;
		logic [TS_W-1:0]    t;
	} route_result_t;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               start = 1'b0;
	logic [1:0]         opcode = '0;
	logic [CH_W-1:0]    channel = '0;
	logic [LABEL_W-1:0] label = '0;
	logic [TS_W-1:0]    timestamp = '0;
	logic [TS_W-1:0]    delay_value = '0;
	logic               cfg_we = 1'b0;
	logic [MASK_W-1:0]  cfg_wdata = '0;
	logic               busy;
	logic               done;
	logic [1:0]         status;
	logic [CH_W-1:0]    out_channel;
	logic [LABEL_W-1:0] out_label;
	logic [TS_W-1:0]    out_time;

	logic [TS_W-1:0]    delay_shadow [TABLE_DEPTH];
	logic [MASK_W-1:0]  mask_shadow;
	route_result_t      expected_routes [$];
	int                 error_count = 0;
	int                 cycle_count = 0;
	int                 send_idle_pct = 0;
	logic [CH_W-1:0]    hot_ch [HOT_ENTRIES];
	logic [LABEL_W-1:0] hot_lab [HOT_ENTRIES];

	spike_event_label_router uut (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.busy        (busy),
		.opcode      (opcode),
		.channel     (channel),
		.label       (label),
		.timestamp   (timestamp),
		.delay_value (delay_value),
		.cfg_we      (cfg_we),
		.cfg_wdata   (cfg_wdata),
		.done        (done),
		.status      (status),
		.out_channel (out_channel),
		.out_label   (out_label),
		.out_time    (out_time)
	);

	always #5 clk = ~clk;

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("simulation failed");
			$finish;
		end
	end

	// Route one beat through the shadow state and update the delay table on writes.
	function automatic route_result_t predict_route(input route_item_t it);
		route_result_t r;
		logic hit;
		logic toward_chip;
		int idx;
		hit = (int'(it.ch) < CHANNELS) && (int'(it.lab) < LABELS);
		idx = int'(it.ch) * LABELS + int'(it.lab);
		toward_chip = mask_shadow[(int'(it.ch) * 8 + int'(it.lab) / 64) % 64];
		r.st = ST_REJECT;
		r.ch = it.ch;
		r.lab = it.lab;
		r.t = '0;
		case (it.op)
			OP_CHIP_EVT: begin
				if (hit && !toward_chip) begin
					r.st = ST_TO_HOST;
					r.t = TS_W'(it.ts + delay_shadow[idx]) & TIME_MASK;
				end
			end
			OP_HOST_EVT: begin
				if (hit && toward_chip) begin
					r.st = ST_TO_CHIP;
					r.t = it.ts & TIME_MASK;
				end
			end
			OP_ROUTE_WR: begin
				if (hit)
					delay_shadow[idx] = it.dv;
				r.st = ST_WRITE;
			end
			default: begin
				r.st = ST_REJECT;
			end
		endcase
		return r;
	endfunction

	// Drive one beat; hold it until the block takes it, then queue its route.
	task automatic send_beat(input logic [1:0] op, input logic [CH_W-1:0] ch,
			input logic [LABEL_W-1:0] lab, input logic [TS_W-1:0] ts,
			input logic [TS_W-1:0] dv);
		route_item_t it;
		it = {op, ch, lab, ts, dv};
		while ($urandom_range(99) < send_idle_pct) begin
			start <= 1'b0;
			@(posedge clk);
		end
		start <= 1'b1;
		opcode <= op;
		channel <= ch;
		label <= lab;
		timestamp <= ts;
		delay_value <= dv;
		do @(posedge clk); while (busy);
		expected_routes.push_back(predict_route(it));
	endtask

	task automatic wait_drained();
		start <= 1'b0;
		do @(posedge clk); while (expected_routes.size() != 0);
	endtask

	task automatic write_mask(input logic [MASK_W-1:0] value);
		cfg_we <= 1'b1;
		cfg_wdata <= value;
		@(posedge clk);
		cfg_we <= 1'b0;
		mask_shadow = value;
		@(posedge clk);
	endtask

	always @(posedge clk) begin
		route_result_t exp_r;
		if (arst_n && done) begin
			if (expected_routes.size() == 0) begin
				$display("%0t: unexpected result status %0d channel %0d label %0d time %0d",
					$time, status, out_channel, out_label, out_time);
				error_count++;
			end else begin
				exp_r = expected_routes.pop_front();
				if (status !== exp_r.st) begin
					$display("%0t: status expected %0d got %0d", $time, exp_r.st, status);
					error_count++;
				end
				if (out_channel !== exp_r.ch) begin
					$display("%0t: out_channel expected %0d got %0d", $time, exp_r.ch,
						out_channel);
					error_count++;
				end
				if (out_label !== exp_r.lab) begin
					$display("%0t: out_label expected %0d got %0d", $time, exp_r.lab, out_label);
					error_count++;
				end
				if (out_time !== exp_r.t) begin
					$display("%0t: out_time expected %0d got %0d", $time, exp_r.t, out_time);
					error_count++;
				end
			end
		end
	end

	// Mask and table at their reset values: zero delay, everything bound for the host.
	task automatic test_reset_state();
		send_idle_pct = 0;
		send_beat(OP_CHIP_EVT, 3'd0, 9'd0, 15'd0, 15'd0);
		send_beat(OP_CHIP_EVT, 3'd7, 9'd511, 15'h7fff, 15'h7fff);
		send_beat(OP_HOST_EVT, 3'd7, 9'd511, 15'h7fff, 15'd0);
		send_beat(OP_UNUSED, 3'd5, 9'h0aa, 15'h1234, 15'h7fff);
	endtask

	// Back-to-back write and read of one entry, and wrap of the delayed time.
	task automatic test_delay_table();
		send_idle_pct = 0;
		send_beat(OP_ROUTE_WR, 3'd7, 9'd511, 15'h7fff, 15'h7fff);
		send_beat(OP_CHIP_EVT, 3'd7, 9'd511, 15'h7fff, 15'd0);
		send_beat(OP_ROUTE_WR, 3'd0, 9'd0, 15'd0, 15'd1);
		send_beat(OP_CHIP_EVT, 3'd0, 9'd0, 15'h7fff, 15'd0);
		send_beat(OP_ROUTE_WR, 3'd3, 9'h155, 15'h2aaa, 15'h2aaa);
		send_beat(OP_CHIP_EVT, 3'd3, 9'h155, 15'h5555, 15'h5555);
		send_beat(OP_CHIP_EVT, 3'd3, 9'h154, 15'h5555, 15'h5555);
	endtask

	task automatic test_direction_mask();
		send_idle_pct = 0;
		wait_drained();
		write_mask(MASK_ONES);
		send_beat(OP_HOST_EVT, 3'd7, 9'd511, 15'h7fff, 15'h7fff);
		send_beat(OP_CHIP_EVT, 3'd7, 9'd511, 15'h7fff, 15'd0);
		send_beat(OP_UNUSED, 3'd0, 9'd0, 15'd0, 15'd0);
		wait_drained();
		// only the top group of channel 7 points at the chip
		write_mask(64'h8000_0000_0000_0000);
		send_beat(OP_HOST_EVT, 3'd7, 9'd448, 15'h0f0f, 15'd0);
		send_beat(OP_HOST_EVT, 3'd7, 9'd447, 15'h0f0f, 15'd0);
		send_beat(OP_CHIP_EVT, 3'd7, 9'd447, 15'h0f0f, 15'd0);
		send_beat(OP_CHIP_EVT, 3'd7, 9'd448, 15'h0f0f, 15'd0);
		wait_drained();
		write_mask(64'h0000_0000_0000_0001);
		send_beat(OP_HOST_EVT, 3'd0, 9'd63, 15'h0001, 15'd0);
		send_beat(OP_HOST_EVT, 3'd0, 9'd64, 15'h0001, 15'd0);
	endtask

	// Mixed traffic over a few hot entries, with write-then-event pairs.
	task automatic test_random_traffic(input int n_items, input int idle_pct,
			input logic [MASK_W-1:0] mask);
		int sent;
		int k;
		int roll;
		bit paused;
		logic [CH_W-1:0] ch;
		logic [LABEL_W-1:0] lab;
		wait_drained();
		write_mask(mask);
		send_idle_pct = idle_pct;
		for (k = 0; k < HOT_ENTRIES; k++) begin
			hot_ch[k] = CH_W'($urandom_range(7));
			hot_lab[k] = LABEL_W'($urandom_range(511));
		end
		hot_ch[0] = '0;
		hot_lab[0] = '0;
		hot_ch[1] = '1;
		hot_lab[1] = '1;
		sent = 0;
		paused = 1'b0;
		while (sent < n_items) begin
			if ($urandom_range(99) < 60) begin
				k = $urandom_range(HOT_ENTRIES - 1);
				ch = hot_ch[k];
				lab = hot_lab[k];
			end else begin
				ch = CH_W'($urandom_range(7));
				lab = LABEL_W'($urandom_range(511));
			end
			roll = $urandom_range(99);
			if (roll < 25) begin
				send_beat(OP_ROUTE_WR, ch, lab, TS_W'($urandom_range(32767)),
					TS_W'($urandom_range(32767)));
				send_beat(($urandom_range(1) == 0) ? OP_CHIP_EVT : OP_HOST_EVT, ch, lab,
					TS_W'($urandom_range(32767)), TS_W'($urandom_range(32767)));
				sent += 2;
			end else begin
				send_beat((roll < 45) ? OP_ROUTE_WR : (roll < 70) ? OP_CHIP_EVT :
					(roll < 92) ? OP_HOST_EVT : OP_UNUSED, ch, lab,
					TS_W'($urandom_range(32767)), TS_W'($urandom_range(32767)));
				sent++;
			end
			// hold off once mid-phase until every route is back
			if (!paused && sent >= n_items / 2) begin
				paused = 1'b1;
				wait_drained();
			end
		end
	endtask

	initial begin
		foreach (delay_shadow[i])
			delay_shadow[i] = '0;
		mask_shadow = '0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		test_reset_state();
		test_delay_table();
		test_direction_mask();
		test_random_traffic(400, 37, {$urandom, $urandom});
		test_random_traffic(400, 80, MASK_ODD_GROUPS);
		test_random_traffic(400, 0, {$urandom, $urandom});
		wait_drained();
		repeat (6) @(posedge clk);
		if (error_count == 0 && expected_routes.size() == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule

[filelist.f]
+incdir+sv
sv/selr_pkg.sv
sv/selr_ram.sv
sv/selr_route.sv
sv/spike_event_label_router.sv
tb/tb_spike_event_label_router.sv
